[rtl/autoscaling_request_dispatcher_core_macros.svh]
// Assertion macros shared by the checker of the dispatcher core.
// No dependencies.
`ifndef AUTOSCALING_REQUEST_DISPATCHER_CORE_MACROS_SVH
`define AUTOSCALING_REQUEST_DISPATCHER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ARD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define ARD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/ard_pkg.sv]
// Package of the autoscaling request dispatcher: constants, types, states.
// No dependencies.
`timescale 1ns / 1ps
package ard_pkg;
  localparam int MAX_SERVERS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4096;
  localparam int TIME_BITS_DEF   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SERVERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_UP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DOWN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKED      = 3'd4;
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_READ     = 6'b000010,
    ST_DISPATCH = 6'b000100,
    ST_COUNT    = 6'b001000,
    ST_SCALE    = 6'b010000,
    ST_OUT      = 6'b100000
  } seq_state_t;

  // Command from the sequencer to the server bank for one walk step.
  typedef struct packed {
    logic       load;
    logic       tick;
    logic       clear_hi;
  } srv_cmd_t;

  // Result beat as held in the output register.
  typedef struct packed {
    logic [12:0] queue_length;
    logic [4:0]  server_count;
    logic [4:0]  active_servers;
    logic [31:0] processed_total;
    logic [31:0] dropped_total;
    logic [31:0] generated_total;
    logic [31:0] scale_up_total;
    logic [31:0] scale_down_total;
    logic [12:0] peak_queue;
    logic [4:0]  peak_servers;
    logic [4:0]  fewest_servers;
    logic [1:0]  scale_event;
  } res_beat_t;
endpackage

[rtl/ard_if.sv]
// Valid/ready channel interface carrying a payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface ard_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/ard_fifo.sv]
// Request FIFO: a memory of service times with a registered read port.
// Depends on nothing; pure generic storage.
`timescale 1ns / 1ps
module ard_fifo #(
  parameter int DEPTH = 4096,
  parameter int TW    = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [TW-1:0]            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [TW-1:0]            rd_data
);
  logic [TW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

[rtl/autoscaling_request_dispatcher_core.sv]
// Top level of the autoscaling request dispatcher.
// Depends on ard_pkg, ard_if and ard_fifo.
//
// Channel  Modport  Payload
// in_      sink     has_request, source_address, service_time
// out_     source   queue_length .. scale_event
// cfg_     write    cfg_we, cfg_idx, cfg_data
//
// A tick runs through the accept step, a FIFO read and a dispatch for each
// server in use, a count-down for each server in use, a scaling step, and a
// tally walk over all MAX_SERVERS slots; a new tick is accepted only once the
// last one is through. The single FIFO read port and the shared walk index
// make this walk serial. Reset is synchronous and needs no clearing pass.
// The result beat sits in its own output register, so the next tick is
// accepted at once; a result still waiting on out_ holds the following tick
// at its last tally cycle until the beat is taken.
`timescale 1ns / 1ps
module autoscaling_request_dispatcher_core #(
  parameter int MAX_SERVERS = ard_pkg::MAX_SERVERS_DEF,
  parameter int QUEUE_DEPTH = ard_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = ard_pkg::TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                          cfg_we,
  input  logic [ard_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ard_pkg::CFG_DATA_W-1:0] cfg_data,
  ard_if.sink   in_ch,
  ard_if.source out_ch
);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int SIW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int SCW = $clog2(MAX_SERVERS + 1);
  localparam logic [31:0] SAT = 32'hFFFF_FFFF;

  // Configuration registers.
  logic [7:0]  up_r, down_r;
  logic [9:0]  cool_cfg_r;
  logic [23:0] blocked_r;

  // Tick state.
  ard_pkg::seq_state_t st_r;
  logic [TIME_BITS-1:0] rem_r [MAX_SERVERS];
  logic [QAW-1:0] head_r;
  logic [QFW-1:0] fill_r, peak_q_r;
  logic [SCW-1:0] nsrv_r, peak_s_r, few_s_r, active_r;
  logic [SIW-1:0] idx_r;
  logic [9:0]  cool_r;
  logic [31:0] proc_r, drop_r, gen_r, up_tot_r, down_tot_r;
  logic [1:0]  ev_r;
  logic        out_valid_r;

  // Output register and its load.
  ard_pkg::res_beat_t res_r, res_nxt;
  logic [SCW-1:0] act_sum;
  logic out_load;

  logic [QAW-1:0] wr_addr;
  logic [TIME_BITS-1:0] rd_data;
  logic push;
  logic [SCW-1:0] cfg_n;

  // The pushed entry lands at head+fill, wrapping at the depth.
  logic [QAW:0] pos_sum;
  assign pos_sum = {1'b0, head_r} + QFW'(fill_r);
  assign wr_addr = (pos_sum >= (QAW+1)'(QUEUE_DEPTH)) ?
                   QAW'(pos_sum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(pos_sum);
  assign push = in_ch.valid && in_ch.ready && in_ch.data.has_request &&
                (in_ch.data.source_address[31:8] != blocked_r) &&
                (fill_r < QFW'(QUEUE_DEPTH));

  ard_fifo #(.DEPTH(QUEUE_DEPTH), .TW(TIME_BITS)) u_fifo (
    .clk(clk), .wr_en(push), .wr_addr(wr_addr),
    .wr_data(in_ch.data.service_time[TIME_BITS-1:0]),
    .rd_addr(head_r), .rd_data(rd_data)
  );

  assign in_ch.ready = (st_r == ard_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_r;

  // Clamp the initial server count into 1..MAX_SERVERS.
  always_comb begin
    if (cfg_data[4:0] == 5'd0) cfg_n = SCW'(1);
    else if (32'(cfg_data[4:0]) > MAX_SERVERS) cfg_n = SCW'(MAX_SERVERS);
    else cfg_n = SCW'(cfg_data[4:0]);
  end

  // Scaling thresholds: 8 by SCW bit products, one each.
  logic [8+SCW-1:0] up_lim, down_lim;
  assign up_lim   = (8+SCW)'(up_r) * (8+SCW)'(nsrv_r);
  assign down_lim = (8+SCW)'(down_r) * (8+SCW)'(nsrv_r);
  logic [SCW-1:0] last_idx;
  assign last_idx = SCW'(idx_r) + SCW'(1);

  // Busy count including the slot under the walk index.
  assign act_sum = active_r +
                   ((SCW'(idx_r) < nsrv_r && rem_r[idx_r] != '0) ? SCW'(1) : SCW'(0));

  // The finished tick moves into the output register once it is free.
  assign out_load = (st_r == ard_pkg::ST_OUT) && (32'(idx_r) == MAX_SERVERS - 1) &&
                    (!out_valid_r || out_ch.ready);

  always_comb begin
    res_nxt.queue_length     = 13'(fill_r);
    res_nxt.server_count     = 5'(nsrv_r);
    res_nxt.active_servers   = 5'(act_sum);
    res_nxt.processed_total  = proc_r;
    res_nxt.dropped_total    = drop_r;
    res_nxt.generated_total  = gen_r;
    res_nxt.scale_up_total   = up_tot_r;
    res_nxt.scale_down_total = down_tot_r;
    res_nxt.peak_queue       = 13'(peak_q_r);
    res_nxt.peak_servers     = 5'(peak_s_r);
    res_nxt.fewest_servers   = 5'(few_s_r);
    res_nxt.scale_event      = ev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_r <= '0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      res_r <= res_nxt;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ard_pkg::ST_IDLE;
      up_r <= 8'd80; down_r <= 8'd50; cool_cfg_r <= 10'd50;
      blocked_r <= 24'hC0A801;
      for (int i = 0; i < MAX_SERVERS; i++) rem_r[i] <= '0;
      head_r <= '0; fill_r <= '0; peak_q_r <= '0;
      nsrv_r <= SCW'(1); peak_s_r <= SCW'(1); few_s_r <= SCW'(1);
      active_r <= '0; idx_r <= '0; cool_r <= '0;
      proc_r <= '0; drop_r <= '0; gen_r <= '0; up_tot_r <= '0; down_tot_r <= '0;
      ev_r <= ard_pkg::EV_NONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          ard_pkg::REG_INIT_SERVERS: begin
            nsrv_r <= cfg_n; peak_s_r <= cfg_n; few_s_r <= cfg_n;
            for (int i = 0; i < MAX_SERVERS; i++)
              if (SCW'(i) >= cfg_n) rem_r[i] <= '0;
          end
          ard_pkg::REG_SCALE_UP:   up_r <= cfg_data[7:0];
          ard_pkg::REG_SCALE_DOWN: down_r <= cfg_data[7:0];
          ard_pkg::REG_COOLDOWN:   cool_cfg_r <= cfg_data[9:0];
          ard_pkg::REG_BLOCKED:    blocked_r <= cfg_data[23:0];
          default: ;
        endcase
      end
      unique case (st_r)
        ard_pkg::ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (in_ch.data.has_request) begin
              if (!push) begin
                if (drop_r != SAT) drop_r <= drop_r + 32'd1;
              end else begin
                fill_r <= fill_r + QFW'(1);
                if (gen_r != SAT) gen_r <= gen_r + 32'd1;
              end
            end
            idx_r <= '0; active_r <= '0;
            st_r <= ard_pkg::ST_READ;
          end
        end
        // Registered read of the head entry for the server at idx_r.
        ard_pkg::ST_READ: st_r <= ard_pkg::ST_DISPATCH;
        ard_pkg::ST_DISPATCH: begin
          if (rem_r[idx_r] == '0 && fill_r != '0) begin
            rem_r[idx_r] <= rd_data;
            head_r <= (32'(head_r) == QUEUE_DEPTH - 1) ? '0 : head_r + QAW'(1);
            fill_r <= fill_r - QFW'(1);
          end
          if (last_idx >= nsrv_r) begin
            idx_r <= '0; st_r <= ard_pkg::ST_COUNT;
          end else begin
            idx_r <= idx_r + SIW'(1); st_r <= ard_pkg::ST_READ;
          end
        end
        ard_pkg::ST_COUNT: begin
          if (rem_r[idx_r] != '0) begin
            rem_r[idx_r] <= rem_r[idx_r] - TIME_BITS'(1);
            if (rem_r[idx_r] == TIME_BITS'(1)) begin
              if (proc_r != SAT) proc_r <= proc_r + 32'd1;
            end
          end
          if (last_idx >= nsrv_r) begin
            st_r <= ard_pkg::ST_SCALE;
          end else begin
            idx_r <= idx_r + SIW'(1);
          end
        end
        ard_pkg::ST_SCALE: begin
          ev_r <= ard_pkg::EV_NONE;
          if (fill_r > peak_q_r) peak_q_r <= fill_r;
          if (nsrv_r > peak_s_r) peak_s_r <= nsrv_r;
          if (nsrv_r < few_s_r) few_s_r <= nsrv_r;
          if (cool_r != '0) begin
            cool_r <= cool_r - 10'd1;
          end else if ((8+SCW)'(fill_r) > up_lim) begin
            if (32'(nsrv_r) < MAX_SERVERS) begin
              rem_r[SIW'(nsrv_r)] <= '0;
              nsrv_r <= nsrv_r + SCW'(1);
              if (up_tot_r != SAT) up_tot_r <= up_tot_r + 32'd1;
              cool_r <= cool_cfg_r; ev_r <= ard_pkg::EV_UP;
            end
          end else if ((8+SCW)'(fill_r) < down_lim && nsrv_r > SCW'(1)) begin
            rem_r[SIW'(nsrv_r - SCW'(1))] <= '0;
            nsrv_r <= nsrv_r - SCW'(1);
            if (down_tot_r != SAT) down_tot_r <= down_tot_r + 32'd1;
            cool_r <= cool_cfg_r; ev_r <= ard_pkg::EV_DOWN;
          end
          idx_r <= '0;
          st_r <= ard_pkg::ST_OUT;
        end
        ard_pkg::ST_OUT: begin
          // Tally busy servers one per cycle; the last slot goes straight
          // into the output register, the walk waiting at it while a beat is held.
          if (32'(idx_r) != MAX_SERVERS - 1) begin
            active_r <= act_sum;
            idx_r <= idx_r + SIW'(1);
          end else if (out_load) begin
            st_r <= ard_pkg::ST_IDLE;
          end
        end
        default: st_r <= ard_pkg::ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_ch.data.queue_length     = res_r.queue_length;
    out_ch.data.server_count     = res_r.server_count;
    out_ch.data.active_servers   = res_r.active_servers;
    out_ch.data.processed_total  = res_r.processed_total;
    out_ch.data.dropped_total    = res_r.dropped_total;
    out_ch.data.generated_total  = res_r.generated_total;
    out_ch.data.scale_up_total   = res_r.scale_up_total;
    out_ch.data.scale_down_total = res_r.scale_down_total;
    out_ch.data.peak_queue       = res_r.peak_queue;
    out_ch.data.peak_servers     = res_r.peak_servers;
    out_ch.data.fewest_servers   = res_r.fewest_servers;
    out_ch.data.scale_event      = res_r.scale_event;
  end
endmodule

[rtl/ard_checker.sv]
// Port-level checker of the dispatcher core, bound to the top level.
// Depends on autoscaling_request_dispatcher_core_macros.svh.
`timescale 1ns / 1ps
`include "autoscaling_request_dispatcher_core_macros.svh"
module ard_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [4:0] server_count,
  input logic [4:0] peak_servers,
  input logic [4:0] fewest_servers,
  input logic [1:0] scale_event
);
  `ARD_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `ARD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(server_count) && $stable(scale_event))
  `ARD_ASSERT_IMP(a_extremes, clk, rst_n, out_valid, fewest_servers <= peak_servers && scale_event != 2'd3)
endmodule

bind autoscaling_request_dispatcher_core ard_checker u_ard_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .server_count(out_ch.data.server_count),
  .peak_servers(out_ch.data.peak_servers),
  .fewest_servers(out_ch.data.fewest_servers),
  .scale_event(out_ch.data.scale_event)
);

[tb/ard_tb_pkg.sv]
// Beat layouts of the dispatcher channels as the testbench drives and samples them.
// Depends on ard_pkg for the register index width.
`timescale 1ns / 1ps
package ard_tb_pkg;
  // An index past the last register; writes to it must change nothing.
  localparam logic [ard_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic        has_request;
    logic [31:0] source_address;
    logic [11:0] service_time;
  } tick_req_t;

  typedef struct packed {
    logic [12:0] queue_length;
    logic [4:0]  server_count;
    logic [4:0]  active_servers;
    logic [31:0] processed_total;
    logic [31:0] dropped_total;
    logic [31:0] generated_total;
    logic [31:0] scale_up_total;
    logic [31:0] scale_down_total;
    logic [12:0] peak_queue;
    logic [4:0]  peak_servers;
    logic [4:0]  fewest_servers;
    logic [1:0]  scale_event;
  } tick_res_t;
endpackage

[tb/autoscaling_request_dispatcher_core_test.sv]
// Self-checking testbench of autoscaling_request_dispatcher_core.
// Depends on ard_pkg, ard_tb_pkg, ard_if and the core itself.
`timescale 1ns / 1ps
module autoscaling_request_dispatcher_core_test;
  localparam int NSRV = 16;
  localparam int QDEPTH = 4096;
  // Quiet cycles after the last result.
  localparam int SETTLE_CYCLES = 100;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 6000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ard_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [ard_pkg::CFG_DATA_W-1:0] cfg_data;

  ard_if #(.payload_t(ard_tb_pkg::tick_req_t)) in_ch (clk);
  ard_if #(.payload_t(ard_tb_pkg::tick_res_t)) out_ch (clk);

  autoscaling_request_dispatcher_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow copy of the dispatcher: registers and tick state.
  logic [4:0]  reg_servers;
  logic [7:0]  reg_up_per_srv;
  logic [7:0]  reg_down_per_srv;
  logic [9:0]  reg_cooldown;
  logic [23:0] reg_blocked;
  logic [11:0] fifo_mem [QDEPTH];
  int          fifo_head;
  int          fifo_fill;
  logic [11:0] busy_left [NSRV];
  int          srv_count;
  int          cool_left;
  logic [31:0] n_done, n_drop, n_gen, n_up, n_down;
  int          queue_peak, srv_peak, srv_fewest;

  ard_tb_pkg::tick_res_t expected_results [$];
  int        check_fails;
  int        send_idle;     // percent of cycles the sender holds back
  int        recv_idle;     // percent of cycles the receiver holds back
  int        hold_cycles;   // long receiver hold-off, counted down below
  int        quiet_cycles;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function void clear_model();
    reg_servers = 5'd1;
    reg_up_per_srv = 8'd80;
    reg_down_per_srv = 8'd50;
    reg_cooldown = 10'd50;
    reg_blocked = 24'hC0A801;
    fifo_head = 0;
    fifo_fill = 0;
    for (int i = 0; i < NSRV; i++) busy_left[i] = '0;
    srv_count = 1;
    cool_left = 0;
    n_done = '0; n_drop = '0; n_gen = '0; n_up = '0; n_down = '0;
    queue_peak = 0;
    srv_peak = 1;
    srv_fewest = 1;
  endfunction

  function void apply_reg(logic [ard_pkg::CFG_IDX_W-1:0] idx,
                          logic [ard_pkg::CFG_DATA_W-1:0] val);
    int n;
    case (idx)
      ard_pkg::REG_INIT_SERVERS: begin
        reg_servers = val[4:0];
        // Out-of-range counts clamp; servers past the new count go idle.
        n = (reg_servers < 1) ? 1 : (reg_servers > NSRV) ? NSRV : reg_servers;
        srv_count = n;
        for (int i = n; i < NSRV; i++) busy_left[i] = '0;
        srv_peak = n;
        srv_fewest = n;
      end
      ard_pkg::REG_SCALE_UP:   reg_up_per_srv = val[7:0];
      ard_pkg::REG_SCALE_DOWN: reg_down_per_srv = val[7:0];
      ard_pkg::REG_COOLDOWN:   reg_cooldown = val[9:0];
      ard_pkg::REG_BLOCKED:    reg_blocked = val[23:0];
      default: ;
    endcase
  endfunction

  // Advances the shadow state by one tick and returns the beat it yields.
  function ard_tb_pkg::tick_res_t dispatch_tick(ard_tb_pkg::tick_req_t r);
    ard_tb_pkg::tick_res_t res;
    int        busy;
    logic [1:0] ev;
    busy = 0;
    ev = ard_pkg::EV_NONE;
    if (r.has_request) begin
      if (r.source_address[31:8] == reg_blocked || fifo_fill >= QDEPTH) begin
        n_drop = sat_inc(n_drop);
      end else begin
        fifo_mem[(fifo_head + fifo_fill) % QDEPTH] = r.service_time;
        fifo_fill++;
        n_gen = sat_inc(n_gen);
      end
    end
    // Idle servers pull from the head in index order.
    for (int i = 0; i < srv_count; i++) begin
      if (busy_left[i] == 0 && fifo_fill > 0) begin
        busy_left[i] = fifo_mem[fifo_head];
        fifo_head = (fifo_head + 1) % QDEPTH;
        fifo_fill--;
      end
    end
    for (int i = 0; i < srv_count; i++) begin
      if (busy_left[i] != 0) begin
        busy_left[i]--;
        if (busy_left[i] == 0) n_done = sat_inc(n_done);
      end
    end
    if (fifo_fill > queue_peak) queue_peak = fifo_fill;
    if (srv_count > srv_peak) srv_peak = srv_count;
    if (srv_count < srv_fewest) srv_fewest = srv_count;
    // A scale-up wanted at the ceiling does nothing and skips the down test.
    if (cool_left > 0) begin
      cool_left--;
    end else if (fifo_fill > reg_up_per_srv * srv_count) begin
      if (srv_count < NSRV) begin
        busy_left[srv_count] = '0;
        srv_count++;
        n_up = sat_inc(n_up);
        cool_left = reg_cooldown;
        ev = ard_pkg::EV_UP;
      end
    end else if (fifo_fill < reg_down_per_srv * srv_count && srv_count > 1) begin
      srv_count--;
      busy_left[srv_count] = '0;
      n_down = sat_inc(n_down);
      cool_left = reg_cooldown;
      ev = ard_pkg::EV_DOWN;
    end
    for (int i = 0; i < srv_count; i++) if (busy_left[i] != 0) busy++;
    res.queue_length = fifo_fill[12:0];
    res.server_count = srv_count[4:0];
    res.active_servers = busy[4:0];
    res.processed_total = n_done;
    res.dropped_total = n_drop;
    res.generated_total = n_gen;
    res.scale_up_total = n_up;
    res.scale_down_total = n_down;
    res.peak_queue = queue_peak[12:0];
    res.peak_servers = srv_peak[4:0];
    res.fewest_servers = srv_fewest[4:0];
    res.scale_event = ev;
    return res;
  endfunction

  function bit work_pending();
    if (fifo_fill > 0) return 1'b1;
    for (int i = 0; i < srv_count; i++) if (busy_left[i] != 0) return 1'b1;
    return 1'b0;
  endfunction

  function ard_tb_pkg::tick_req_t make_req(logic has, logic [31:0] addr, logic [11:0] st);
    ard_tb_pkg::tick_req_t r;
    r.has_request = has;
    r.source_address = addr;
    r.service_time = st;
    return r;
  endfunction

  // Mostly real requests with short jobs, a share from the blocked subnet,
  // and now and then a zero or a very long service time.
  function ard_tb_pkg::tick_req_t random_req();
    int pick;
    logic [31:0] addr;
    logic [11:0] st;
    addr = ($urandom_range(9) < 2) ? {reg_blocked, 8'($urandom)} : $urandom;
    pick = $urandom_range(99);
    if (pick < 2) st = '0;
    else if (pick < 4) st = 12'($urandom);
    else st = 12'($urandom_range(30, 1));
    return make_req($urandom_range(9) < 8, addr, st);
  endfunction

  task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
    check_fails++;
  endtask

  // One tick beat: optional idle cycles, then valid held until accepted.
  // Valid stays high afterwards so back-to-back beats need no toggle.
  task send_tick(ard_tb_pkg::tick_req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results = {expected_results, dispatch_tick(r)};
    @(negedge clk);
  endtask

  // Waits until every expected beat is back and the core has gone quiet.
  task settle();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_reg(logic [ard_pkg::CFG_IDX_W-1:0] idx, logic [ard_pkg::CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_reg(idx, val);
  endtask

  // Receiver: random stalls, or a solid hold-off while hold_cycles runs.
  always @(negedge clk) begin
    logic rdy;
    if (hold_cycles > 0) begin
      hold_cycles--;
      rdy = 1'b0;
    end else begin
      rdy = ($urandom_range(99) >= recv_idle);
    end
    out_ch.ready <= rdy;
  end

  // Result checker and hang watchdog.
  always @(posedge clk) begin
    ard_tb_pkg::tick_res_t got, want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          report_mismatch("outstanding beats", 32'd1, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.queue_length !== want.queue_length)
            report_mismatch("queue_length", got.queue_length, want.queue_length);
          if (got.server_count !== want.server_count)
            report_mismatch("server_count", got.server_count, want.server_count);
          if (got.active_servers !== want.active_servers)
            report_mismatch("active_servers", got.active_servers, want.active_servers);
          if (got.processed_total !== want.processed_total)
            report_mismatch("processed_total", got.processed_total, want.processed_total);
          if (got.dropped_total !== want.dropped_total)
            report_mismatch("dropped_total", got.dropped_total, want.dropped_total);
          if (got.generated_total !== want.generated_total)
            report_mismatch("generated_total", got.generated_total, want.generated_total);
          if (got.scale_up_total !== want.scale_up_total)
            report_mismatch("scale_up_total", got.scale_up_total, want.scale_up_total);
          if (got.scale_down_total !== want.scale_down_total)
            report_mismatch("scale_down_total", got.scale_down_total, want.scale_down_total);
          if (got.peak_queue !== want.peak_queue)
            report_mismatch("peak_queue", got.peak_queue, want.peak_queue);
          if (got.peak_servers !== want.peak_servers)
            report_mismatch("peak_servers", got.peak_servers, want.peak_servers);
          if (got.fewest_servers !== want.fewest_servers)
            report_mismatch("fewest_servers", got.fewest_servers, want.fewest_servers);
          if (got.scale_event !== want.scale_event)
            report_mismatch("scale_event", got.scale_event, want.scale_event);
        end
      end
    end
  end

  // Ticks under the reset settings: an empty tick with junk fields, the
  // blocked subnet and its neighbor, address and service-time extremes,
  // and a zero service time that must vanish without being processed.
  task test_reset_defaults();
    send_tick(make_req(1'b0, 32'hFFFF_FFFF, 12'hFFF));
    send_tick(make_req(1'b1, {24'hC0A801, 8'h37}, 12'd5));
    send_tick(make_req(1'b1, {24'hC0A800, 8'hFF}, 12'd3));
    send_tick(make_req(1'b1, 32'h0000_0000, 12'd1));
    send_tick(make_req(1'b1, 32'hFFFF_FFFF, 12'hFFF));
    send_tick(make_req(1'b1, 32'h5A5A_A5A5, 12'd0));
    send_tick(make_req(1'b0, 32'h0, 12'd0));
    settle();
  endtask

  // Register extremes: clamped server counts, zero thresholds, the ceiling
  // case where a scale-up is wanted at sixteen servers, the spare index.
  task test_register_edges();
    write_reg(ard_pkg::REG_INIT_SERVERS, 24'd0);
    send_tick(make_req(1'b1, 32'h0A00_0001, 12'd2));
    settle();
    write_reg(ard_pkg::REG_INIT_SERVERS, 24'hFFFFFF);
    write_reg(ard_pkg::REG_SCALE_UP, 24'd0);
    write_reg(ard_pkg::REG_SCALE_DOWN, 24'd0);
    write_reg(ard_pkg::REG_COOLDOWN, 24'd0);
    write_reg(ard_pkg::REG_BLOCKED, 24'hFFFFFF);
    write_reg(ard_tb_pkg::REG_SPARE, 24'hFFFFFF);
    for (int i = 0; i < 18; i++)
      send_tick(make_req(1'b1, 32'h0B0C_0D0E + i, 12'd20));
    send_tick(make_req(1'b1, 32'hFFFF_FF12, 12'd4));
    settle();
    write_reg(ard_pkg::REG_SCALE_UP, 24'd255);
    write_reg(ard_pkg::REG_SCALE_DOWN, 24'd255);
    write_reg(ard_pkg::REG_COOLDOWN, 24'd1023);
    write_reg(ard_pkg::REG_BLOCKED, 24'd0);
    send_tick(make_req(1'b1, 32'h0000_00FF, 12'd1));
    send_tick(make_req(1'b0, 32'h0, 12'd0));
    settle();
  endtask

  // Build a backlog on one server so the queue grows and servers are added
  // up to the ceiling, then drain it with empty ticks.
  task test_queue_backlog();
    write_reg(ard_pkg::REG_INIT_SERVERS, 24'd1);
    write_reg(ard_pkg::REG_SCALE_UP, 24'd4);
    write_reg(ard_pkg::REG_SCALE_DOWN, 24'd0);
    write_reg(ard_pkg::REG_COOLDOWN, 24'd3);
    write_reg(ard_pkg::REG_BLOCKED, 24'h123456);
    for (int i = 0; i < 200; i++)
      send_tick(make_req(1'b1, $urandom & 32'h7FFF_FFFF, (i < 8) ? 12'd150 : 12'd20));
    while (work_pending()) send_tick(make_req(1'b0, $urandom, 12'($urandom)));
    settle();
  endtask

  // Random traffic under one idle profile, several register settings.
  task test_random_traffic(int s_idle, int r_idle, int beats);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int k = 0; k < 3; k++) begin
      write_reg(ard_pkg::REG_INIT_SERVERS, 24'($urandom_range(NSRV, 1)));
      write_reg(ard_pkg::REG_SCALE_UP, 24'($urandom_range(6)));
      write_reg(ard_pkg::REG_SCALE_DOWN, 24'($urandom_range(3)));
      write_reg(ard_pkg::REG_COOLDOWN, 24'($urandom_range(15)));
      write_reg(ard_pkg::REG_BLOCKED, 24'($urandom));
      for (int i = 0; i < beats / 3; i++) send_tick(random_req());
      settle();
    end
  endtask

  // The receiver stops for a long stretch while ticks keep coming, so the
  // output register fills and the core must stall its input.
  task test_output_holdoff();
    send_idle = 0;
    recv_idle = 0;
    @(negedge clk);
    hold_cycles = 600;
    for (int i = 0; i < 40; i++) send_tick(random_req());
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    check_fails = 0;
    quiet_cycles = 0;
    hold_cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    clear_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_register_edges();
    test_queue_backlog();
    test_random_traffic(15, 74, 400);
    test_random_traffic(74, 15, 400);
    test_random_traffic(0, 0, 400);
    test_output_holdoff();

    settle();
    if (check_fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/ard_pkg.sv
rtl/ard_if.sv
rtl/ard_fifo.sv
rtl/autoscaling_request_dispatcher_core.sv
rtl/ard_checker.sv
tb/ard_tb_pkg.sv
tb/autoscaling_request_dispatcher_core_test.sv
